// File: src/lz_stream_decompressor_assert.svh
// Assertion macros shared by the decompressor modules.
`ifndef LZ_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ_STREAM_DECOMPRESSOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lzd assertion failed");
// Next-cycle implication checked outside reset.
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lzd assertion failed");
`endif

// File: src/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none
package lzd_pkg;
	localparam int unsigned WindowDepthDefault = 524288;
	localparam int unsigned ShortOffsetSpanDefault = 4096;

	typedef enum logic [2:0] {
		PH_HEADER    = 3'd0,
		PH_LITERAL   = 3'd1,
		PH_LIT_EXT   = 3'd2,
		PH_SHORT_OFF = 3'd3,
		PH_LONG_OFF1 = 3'd4,
		PH_LONG_OFF2 = 3'd5,
		PH_LEN_EXT   = 3'd6,
		PH_COPY      = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MISORDER  = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_OFFSET    = 3'd3,
		ST_SRC_END   = 3'd4,
		ST_STOPPED   = 3'd5
	} status_t;

	localparam logic [1:0] REG_SOURCE_LENGTH = 2'd0;
	localparam logic [1:0] REG_OUTPUT_LENGTH = 2'd1;
	localparam logic [1:0] REG_LEN_EXT_OFF   = 2'd2;

	// Word handed from the front to the back.
	typedef struct packed {
		logic       req_type;
		logic [7:0] src_byte;
	} item_t;
endpackage
`default_nettype wire

// File: src/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front
// Input skid queue: accepts words and hands them to the decoder core.
// ----------------------------------------------------------------------------
`default_nettype none
module lzd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire lzd_pkg::item_t in_item,
	output logic               q_valid,
	input  wire logic          q_ready,
	output lzd_pkg::item_t     q_item
);
	// Two-entry queue.
	lzd_pkg::item_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`include "lz_stream_decompressor_assert.svh"
	`LZD_ASSERT_IMPL(a_no_overfill, clk, arst_n, cnt_q == 2'd2, !in_ready)
	`LZD_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
	`LZD_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
endmodule
`default_nettype wire

// File: src/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back
// Token parser, window memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module lzd_back #(
	parameter int unsigned WINDOW_DEPTH = lzd_pkg::WindowDepthDefault,
	parameter int unsigned SHORT_OFFSET_SPAN = lzd_pkg::ShortOffsetSpanDefault
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_ready,
	input  wire lzd_pkg::item_t q_item,
	input  wire logic [31:0]    source_length,
	input  wire logic [31:0]    output_length,
	input  wire logic           length_extension_off,
	output logic                out_valid_hs,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                out_valid,
	output logic                want_source,
	output logic [2:0]          status,
	output logic                source_done
);
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam logic [18:0] SPAN = 19'(SHORT_OFFSET_SPAN);

	logic [7:0] win_q [2**AW];

	lzd_pkg::phase_t ph_q, ph_d;
	logic [31:0] oc_q, oc_d, sc_q, sc_d, rl_q, rl_d, cf_q, cf_d;
	logic [7:0]  th_q, th_d;
	logic [18:0] ob_q, ob_d;
	logic        r255_q, r255_d, fail_q, fail_d;
	lzd_pkg::status_t st;
	logic        emit;
	logic [7:0]  ebyte;
	logic        fwd;
	logic [7:0]  last_q;
	logic        rd_pend_q;
	logic [7:0]  rdata_q;

	// Result register and its pending read byte.
	logic        res_v_q;
	logic        res_mem_q;
	logic [7:0]  res_b_q;
	logic        res_ov_q, res_ws_q, res_sd_q;
	logic [2:0]  res_st_q;

	logic take;
	logic [32:0] sum_ol, sum_sl;
	logic [32:0] ext_sum;

	assign q_ready = !res_v_q || out_ready;
	assign take    = q_valid && q_ready;

	// A copy reads the byte written one item earlier only when the offset is one.
	assign fwd = (cf_q == oc_q - 32'd1) && rd_pend_q;

	assign out_valid_hs = res_v_q;
	assign out_byte     = res_mem_q ? last_q : res_b_q;
	assign out_valid    = res_ov_q;
	assign want_source  = res_ws_q;
	assign status       = res_st_q;
	assign source_done  = res_sd_q;

	always_comb begin
		ph_d = ph_q; oc_d = oc_q; sc_d = sc_q; rl_d = rl_q; cf_d = cf_q;
		th_d = th_q; ob_d = ob_q; r255_d = r255_q; fail_d = fail_q;
		st = lzd_pkg::ST_OK; emit = 1'b0; ebyte = q_item.src_byte;
		sum_ol = 33'd0; sum_sl = 33'd0; ext_sum = 33'd0;
		if (fail_q) begin
			st = lzd_pkg::ST_STOPPED;
		end else if (q_item.req_type) begin
			if (ph_q != lzd_pkg::PH_COPY) begin
				st = lzd_pkg::ST_MISORDER;
			end else begin
				emit = 1'b1;
				oc_d = oc_q + 32'd1;
				cf_d = cf_q + 32'd1;
				rl_d = rl_q - 32'd1;
				if (rl_q == 32'd1) ph_d = lzd_pkg::PH_HEADER;
			end
		end else if (ph_q == lzd_pkg::PH_COPY || sc_q >= source_length) begin
			st = lzd_pkg::ST_MISORDER;
		end else begin
			sc_d = sc_q + 32'd1;
			unique case (ph_q)
				lzd_pkg::PH_HEADER: begin
					th_d = q_item.src_byte;
					if (q_item.src_byte[7:4] == 4'h0) begin
						rl_d = {28'd0, q_item.src_byte[3:0]} + 32'd1;
						r255_d = 1'b0;
						ph_d = lzd_pkg::PH_LITERAL;
					end else if (q_item.src_byte[7:4] == 4'h1) begin
						ph_d = lzd_pkg::PH_LONG_OFF1;
					end else begin
						ph_d = lzd_pkg::PH_SHORT_OFF;
					end
				end
				lzd_pkg::PH_LITERAL: begin
					emit = 1'b1;
					oc_d = oc_q + 32'd1;
					rl_d = rl_q - 32'd1;
					if (rl_q == 32'd1) begin
						if (r255_q ? (th_q == 8'hff) : (th_q[3:0] == 4'hf))
							ph_d = lzd_pkg::PH_LIT_EXT;
						else
							ph_d = lzd_pkg::PH_HEADER;
					end
				end
				lzd_pkg::PH_LIT_EXT: begin
					th_d = q_item.src_byte;
					r255_d = 1'b1;
					rl_d = {24'd0, q_item.src_byte};
					if (q_item.src_byte == 8'd0) ph_d = lzd_pkg::PH_HEADER;
					else ph_d = lzd_pkg::PH_LITERAL;
				end
				lzd_pkg::PH_SHORT_OFF: begin
					ob_d = {7'd0, th_q[3:0], q_item.src_byte} + 19'd1;
					rl_d = {28'd0, th_q[7:4]};
					if (th_q[7:4] == 4'hf && !length_extension_off)
						ph_d = lzd_pkg::PH_LEN_EXT;
					else
						ph_d = lzd_pkg::PH_COPY;
				end
				lzd_pkg::PH_LONG_OFF1: begin
					ob_d = {9'd0, th_q[1:0], q_item.src_byte};
					ph_d = lzd_pkg::PH_LONG_OFF2;
				end
				lzd_pkg::PH_LONG_OFF2: begin
					ob_d = {ob_q[10:0], q_item.src_byte} + SPAN;
					rl_d = {30'd0, th_q[3:2]} + 32'd3;
					if (th_q[3:2] == 2'd3 && !length_extension_off)
						ph_d = lzd_pkg::PH_LEN_EXT;
					else
						ph_d = lzd_pkg::PH_COPY;
				end
				lzd_pkg::PH_LEN_EXT: begin
					ext_sum = {1'b0, rl_q} + {25'd0, q_item.src_byte};
					rl_d = ext_sum[32] ? 32'hffff_ffff : ext_sum[31:0];
					if (q_item.src_byte != 8'hff) ph_d = lzd_pkg::PH_COPY;
				end
				default: ph_d = lzd_pkg::PH_HEADER;
			endcase
			// Checks at the start of a literal run or a copy.
			sum_ol = {1'b0, oc_q} + {1'b0, rl_d};
			sum_sl = {1'b0, sc_d} + {1'b0, rl_d};
			if (ph_d == lzd_pkg::PH_LITERAL && ph_q != lzd_pkg::PH_LITERAL) begin
				if (sum_ol > {1'b0, output_length}) begin
					st = lzd_pkg::ST_OVERFLOW; fail_d = 1'b1;
				end else if (sum_sl > {1'b0, source_length}) begin
					st = lzd_pkg::ST_SRC_END; fail_d = 1'b1;
				end
			end else if (ph_d == lzd_pkg::PH_COPY) begin
				if ({13'd0, ob_d} > oc_q) begin
					st = lzd_pkg::ST_OFFSET; fail_d = 1'b1;
				end else if (sum_ol > {1'b0, output_length}) begin
					st = lzd_pkg::ST_OVERFLOW; fail_d = 1'b1;
				end
				cf_d = oc_q - {13'd0, ob_d};
			end
			if (fail_d) begin
				ph_d = lzd_pkg::PH_HEADER; rl_d = 32'd0; cf_d = cf_q;
			end else if (sc_d >= source_length && ph_d != lzd_pkg::PH_HEADER &&
				ph_d != lzd_pkg::PH_COPY) begin
				st = lzd_pkg::ST_SRC_END; fail_d = 1'b1;
				ph_d = lzd_pkg::PH_HEADER; rl_d = 32'd0;
			end
		end
	end

	// Window: one write and one read a cycle, read data registered.
	always_ff @(posedge clk) begin
		if (take && emit && !q_item.req_type) begin
			win_q[oc_q[AW-1:0]] <= ebyte;
		end else if (take && emit) begin
			win_q[oc_q[AW-1:0]] <= fwd ? last_q : rdata_q;
		end
		if (take && emit && q_item.req_type) begin
			rdata_q <= win_q[cf_q[AW-1:0] + AW'(1)];
		end else if (take && ph_d == lzd_pkg::PH_COPY) begin
			rdata_q <= win_q[cf_d[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= lzd_pkg::PH_HEADER;
			oc_q <= '0; sc_q <= '0; rl_q <= '0; cf_q <= '0;
			th_q <= '0; ob_q <= '0; r255_q <= 1'b0; fail_q <= 1'b0;
			res_v_q <= 1'b0; res_mem_q <= 1'b0; res_b_q <= '0;
			res_ov_q <= 1'b0; res_ws_q <= 1'b0; res_sd_q <= 1'b0;
			res_st_q <= '0; last_q <= '0; rd_pend_q <= 1'b0;
		end else begin
			if (take) begin
				ph_q <= ph_d; oc_q <= oc_d; sc_q <= sc_d; rl_q <= rl_d; cf_q <= cf_d;
				th_q <= th_d; ob_q <= ob_d; r255_q <= r255_d; fail_q <= fail_d;
				res_v_q   <= 1'b1;
				res_mem_q <= emit && q_item.req_type && !fwd;
				res_b_q   <= !emit ? 8'd0 : (q_item.req_type ? last_q : ebyte);
				if (emit) last_q <= q_item.req_type ? (fwd ? last_q : rdata_q) : ebyte;
				rd_pend_q <= 1'b1;
				res_ov_q  <= emit;
				res_st_q  <= st;
				res_ws_q  <= !fail_d && ph_d != lzd_pkg::PH_COPY && sc_d < source_length;
				res_sd_q  <= fail_d || (sc_d >= source_length && ph_d != lzd_pkg::PH_COPY);
			end else if (out_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	`include "lz_stream_decompressor_assert.svh"
	`LZD_ASSERT_IMPL(a_valid_zero_byte, clk, arst_n, res_v_q && !res_ov_q, out_byte == 8'd0)
	`LZD_ASSERT_IMPL(a_fail_stops, clk, arst_n, fail_q && take, st == lzd_pkg::ST_STOPPED)
	`LZD_ASSERT_IMPL(a_copy_len, clk, arst_n, ph_q == lzd_pkg::PH_COPY, rl_q != 32'd0)
endmodule
`default_nettype wire

// File: src/lz_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lz_stream_decompressor
// Streaming LZ77 token decoder with a byte window for match copies.
// ----------------------------------------------------------------------------
// Each input word either feeds one compressed byte (req_type 0) or pulls one
// copied byte (req_type 1); every word yields exactly one result word. The
// block takes one word per cycle: a two-entry queue decouples the input side
// from the decoder, and a result register decouples the decoder from the
// output, so either side may stall. The window memory has one write and one
// registered read port; a copied byte is read ahead of its pull, and copies at
// offset one forward the last output byte. Errors are sticky until reset.
`default_nettype none
module lz_stream_decompressor #(
	parameter int unsigned WINDOW_DEPTH = lzd_pkg::WindowDepthDefault,
	parameter int unsigned SHORT_OFFSET_SPAN = lzd_pkg::ShortOffsetSpanDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [7:0]  src_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             out_valid_hs,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             out_valid,
	output logic             want_source,
	output logic [2:0]       status,
	output logic             source_done
);
	lzd_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;
	logic [31:0] src_len_q, out_len_q;
	logic ext_off_q;

	assign in_item.req_type = req_type;
	assign in_item.src_byte = src_byte;
	assign cfg_ready = 1'b1;

	// Register writes take effect at once; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q <= 32'd2;
			out_len_q <= 32'd0;
			ext_off_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lzd_pkg::REG_SOURCE_LENGTH: src_len_q <= cfg_data;
				lzd_pkg::REG_OUTPUT_LENGTH: out_len_q <= cfg_data;
				lzd_pkg::REG_LEN_EXT_OFF:   ext_off_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lzd_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.q_valid, .q_ready, .q_item
	);

	lzd_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH), .SHORT_OFFSET_SPAN(SHORT_OFFSET_SPAN)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.source_length(src_len_q), .output_length(out_len_q),
		.length_extension_off(ext_off_q),
		.out_valid_hs, .out_ready, .out_byte, .out_valid,
		.want_source, .status, .source_done
	);
endmodule
`default_nettype wire

// File: tb/lz_stream_decompressor_test.sv
// ----------------------------------------------------------------------------
// lz_stream_decompressor_test
// Self-checking bench for the streaming LZ77 token decoder.
// ----------------------------------------------------------------------------
// A short table of directed words runs first. Some of its results are typed
// in by hand, and the rest are checked against the bench's own decoder
// model. Random well-formed token streams follow, with some stray feeds and
// pulls mixed in. Both sides idle at random, and the receiver stalls once for
// a long stretch. The run closes with a clean end of source and then one
// sticky error chosen at random.
`default_nettype none
module lz_stream_decompressor_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic REQ_FEED = 1'b0;
	localparam logic REQ_PULL = 1'b1;
	localparam int unsigned DEPTH = lzd_pkg::WindowDepthDefault;
	localparam int unsigned SPAN = lzd_pkg::ShortOffsetSpanDefault;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic [7:0]       ob;
		logic             ov;
		logic             ws;
		lzd_pkg::status_t st;
		logic             sd;
	} result_t;

	typedef struct {
		logic       rt;
		logic [7:0] b;
		bit         typed;
		result_t    want;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, req_type;
	logic [7:0] src_byte;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic out_valid_hs, out_ready;
	logic [7:0] out_byte;
	logic out_valid, want_source, source_done;
	logic [2:0] status;

	lz_stream_decompressor i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .src_byte(src_byte),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid_hs(out_valid_hs), .out_ready(out_ready),
		.out_byte(out_byte), .out_valid(out_valid),
		.want_source(want_source), .status(status),
		.source_done(source_done)
	);

	// Decoder model state, mirrored from the block's registers.
	logic [31:0]     src_len, out_len;
	logic            ext_off;
	logic [7:0]      window [int];
	logic [31:0]     out_cnt, src_cnt, run_left, copy_from;
	logic [31:0]     offset_build;
	lzd_pkg::phase_t phase;
	logic [7:0]      token_hdr;
	logic            limit_255, failed;
	logic [7:0]      emit_b;
	logic            emit_v;

	result_t     pending_q[$];
	logic [7:0]  token_q[$];
	int          errors = 0;
	bit          calm = 0;
	bit          hold_req = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Check every result word against the oldest expectation.
	initial begin
		result_t e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid_hs && out_ready) begin
				if (pending_q.size() == 0) begin
					report("unexpected word", status, 0);
				end else begin
					e = pending_q.pop_front();
					if (out_byte !== e.ob) report("out_byte", out_byte, e.ob);
					if (out_valid !== e.ov) report("out_valid", out_valid, e.ov);
					if (want_source !== e.ws) report("want_source", want_source, e.ws);
					if (status !== e.st) report("status", status, e.st);
					if (source_done !== e.sd) report("source_done", source_done, e.sd);
				end
			end
		end
	end

	// Receiver: random stall bursts, one long hold on request, none when calm.
	initial begin
		int n;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready = 0;
				for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready = 0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ready = 1;
		end
	end

	function automatic lzd_pkg::status_t fail_with(lzd_pkg::status_t code);
		failed = 1;
		phase = lzd_pkg::PH_HEADER;
		run_left = 0;
		return code;
	endfunction

	function automatic lzd_pkg::status_t start_run();
		if (64'(out_cnt) + 64'(run_left) > 64'(out_len)) return fail_with(lzd_pkg::ST_OVERFLOW);
		if (64'(src_cnt) + 64'(run_left) > 64'(src_len)) return fail_with(lzd_pkg::ST_SRC_END);
		phase = lzd_pkg::PH_LITERAL;
		return lzd_pkg::ST_OK;
	endfunction

	function automatic lzd_pkg::status_t start_copy();
		if (offset_build > out_cnt) return fail_with(lzd_pkg::ST_OFFSET);
		if (64'(out_cnt) + 64'(run_left) > 64'(out_len)) return fail_with(lzd_pkg::ST_OVERFLOW);
		copy_from = out_cnt - offset_build;
		phase = lzd_pkg::PH_COPY;
		return lzd_pkg::ST_OK;
	endfunction

	function automatic void emit(logic [7:0] v);
		window[out_cnt % DEPTH] = v;
		out_cnt++;
		emit_b = v;
		emit_v = 1;
	endfunction

	function automatic lzd_pkg::status_t feed(logic [7:0] b);
		lzd_pkg::status_t st;
		bit full;
		st = lzd_pkg::ST_OK;
		src_cnt++;
		case (phase)
			lzd_pkg::PH_HEADER: begin
				token_hdr = b;
				if (b[7:4] == 4'h0) begin
					run_left = {28'd0, b[3:0]} + 32'd1;
					limit_255 = 0;
					st = start_run();
				end else if (b[7:4] == 4'h1) begin
					phase = lzd_pkg::PH_LONG_OFF1;
				end else begin
					phase = lzd_pkg::PH_SHORT_OFF;
				end
			end
			lzd_pkg::PH_LITERAL: begin
				emit(b);
				run_left--;
				if (run_left == 0) begin
					full = limit_255 ? (token_hdr == 8'hff) : (token_hdr[3:0] == 4'hf);
					phase = full ? lzd_pkg::PH_LIT_EXT : lzd_pkg::PH_HEADER;
				end
			end
			lzd_pkg::PH_LIT_EXT: begin
				token_hdr = b;
				limit_255 = 1;
				run_left = {24'd0, b};
				if (b == 0) phase = lzd_pkg::PH_HEADER;
				else st = start_run();
			end
			lzd_pkg::PH_SHORT_OFF: begin
				offset_build = {20'd0, token_hdr[3:0], b} + 32'd1;
				run_left = {28'd0, token_hdr[7:4]};
				if (run_left == 15 && !ext_off) phase = lzd_pkg::PH_LEN_EXT;
				else st = start_copy();
			end
			lzd_pkg::PH_LONG_OFF1: begin
				offset_build = {22'd0, token_hdr[1:0], b};
				phase = lzd_pkg::PH_LONG_OFF2;
			end
			lzd_pkg::PH_LONG_OFF2: begin
				offset_build = (((offset_build << 8) | {24'd0, b}) + SPAN) & 32'h7ffff;
				run_left = {30'd0, token_hdr[3:2]} + 32'd3;
				if (run_left == 6 && !ext_off) phase = lzd_pkg::PH_LEN_EXT;
				else st = start_copy();
			end
			lzd_pkg::PH_LEN_EXT: begin
				run_left = (run_left > 32'hffffffff - {24'd0, b}) ? 32'hffffffff :
					run_left + {24'd0, b};
				if (b != 8'hff) st = start_copy();
			end
			default: phase = lzd_pkg::PH_HEADER;
		endcase
		if (!failed && src_cnt >= src_len && phase != lzd_pkg::PH_HEADER &&
			phase != lzd_pkg::PH_COPY)
			st = fail_with(lzd_pkg::ST_SRC_END);
		return st;
	endfunction

	// Advance the model by one accepted word and return its result.
	function automatic result_t decode_word(logic rt, logic [7:0] b);
		result_t r;
		emit_b = 0;
		emit_v = 0;
		if (failed) begin
			r.st = lzd_pkg::ST_STOPPED;
		end else if (rt == REQ_PULL) begin
			if (phase != lzd_pkg::PH_COPY) begin
				r.st = lzd_pkg::ST_MISORDER;
			end else begin
				emit(window[copy_from % DEPTH]);
				copy_from++;
				run_left--;
				if (run_left == 0) phase = lzd_pkg::PH_HEADER;
				r.st = lzd_pkg::ST_OK;
			end
		end else if (phase == lzd_pkg::PH_COPY || src_cnt >= src_len) begin
			r.st = lzd_pkg::ST_MISORDER;
		end else begin
			r.st = feed(b);
		end
		r.ob = emit_b;
		r.ov = emit_v;
		r.ws = !failed && phase != lzd_pkg::PH_COPY && src_cnt < src_len;
		r.sd = failed || (src_cnt >= src_len && phase != lzd_pkg::PH_COPY);
		return r;
	endfunction

	// Offer one word from a falling edge, hold it until accepted, then queue
	// its expectation; return on the next falling edge so words can follow
	// back to back.
	task automatic send_word(logic rt, logic [7:0] b, bit typed = 0, result_t want = '0);
		result_t r;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid = 1;
		req_type = rt;
		src_byte = b;
		do @(posedge clk); while (!in_ready);
		r = decode_word(rt, b);
		pending_q.push_back(typed ? want : r);
		@(negedge clk);
		in_valid = 0;
	endtask

	// Write one register once the block has drained.
	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lzd_pkg::REG_SOURCE_LENGTH: src_len = v;
			lzd_pkg::REG_OUTPUT_LENGTH: out_len = v;
			lzd_pkg::REG_LEN_EXT_OFF: ext_off = v[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Queue the bytes of one well-formed token that fits what has been output.
	function automatic void build_token();
		int kind, len, off, n, v;
		kind = $urandom_range(0, 9);
		if (out_cnt == 0 || kind < 4) begin
			len = $urandom_range(0, 15);
			if ($urandom_range(0, 3) == 0) len = 15;
			token_q.push_back(8'(len));
			for (n = 0; n <= len; n++) token_q.push_back(8'($urandom));
			if (len == 15) begin
				do begin
					v = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 20);
					token_q.push_back(8'(v));
					for (n = 0; n < v; n++) token_q.push_back(8'($urandom));
				end while (v == 255);
			end
		end else if (kind < 8 || out_cnt <= SPAN) begin
			len = $urandom_range(2, 15);
			off = $urandom_range(1, (out_cnt < SPAN) ? out_cnt : SPAN);
			if ($urandom_range(0, 3) == 0) off = 1;
			token_q.push_back({4'(len), 4'((off - 1) >> 8)});
			token_q.push_back(8'(off - 1));
			if (len == 15 && !ext_off) begin
				if ($urandom_range(0, 5) == 0) token_q.push_back(8'hff);
				token_q.push_back(8'($urandom_range(0, 12)));
			end
		end else begin
			len = $urandom_range(0, 3);
			off = $urandom_range(SPAN, (out_cnt < 266239) ? out_cnt : 266239);
			v = off - SPAN;
			token_q.push_back({4'h1, 2'(len), 2'(v >> 16)});
			token_q.push_back(8'(v >> 8));
			token_q.push_back(8'(v));
			if (len == 3 && !ext_off) token_q.push_back(8'($urandom_range(0, 12)));
		end
	endfunction

	// Random words until the budget is spent and the parser sits between tokens.
	task automatic random_words(int budget, int calm_from);
		int sent;
		sent = 0;
		while (sent < budget || phase != lzd_pkg::PH_HEADER || token_q.size() != 0) begin
			if (sent >= calm_from) calm = 1;
			if (phase == lzd_pkg::PH_COPY) begin
				if ($urandom_range(0, 19) == 0) send_word(REQ_FEED, 8'($urandom));
				else send_word(REQ_PULL, 8'($urandom));
			end else if ($urandom_range(0, 29) == 0) begin
				send_word(REQ_PULL, 8'($urandom));
			end else begin
				if (token_q.size() == 0) build_token();
				send_word(REQ_FEED, token_q.pop_front());
			end
			sent++;
		end
	endtask

	initial begin
		row_t script[$];
		int i, pick;
		in_valid = 0;
		req_type = REQ_FEED;
		src_byte = 0;
		cfg_valid = 0;
		cfg_index = lzd_pkg::REG_SOURCE_LENGTH;
		cfg_data = 0;
		src_len = 2;
		out_len = 0;
		ext_off = 0;
		out_cnt = 0;
		src_cnt = 0;
		run_left = 0;
		copy_from = 0;
		offset_build = 0;
		phase = lzd_pkg::PH_HEADER;
		token_hdr = 0;
		limit_255 = 0;
		failed = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Pull straight out of reset: nothing to copy.
		send_word(REQ_PULL, 8'h00, 1, '{8'h00, 1'b0, 1'b1, lzd_pkg::ST_MISORDER, 1'b0});
		write_reg(lzd_pkg::REG_SOURCE_LENGTH, 32'hffffffff);
		write_reg(lzd_pkg::REG_OUTPUT_LENGTH, 32'hffffffff);
		write_reg(lzd_pkg::REG_LEN_EXT_OFF, 32'd0);

		script.push_back('{REQ_FEED, 8'h01, 1, '{8'h00, 1'b0, 1'b1, lzd_pkg::ST_OK, 1'b0}});
		script.push_back('{REQ_FEED, 8'h00, 1, '{8'h00, 1'b1, 1'b1, lzd_pkg::ST_OK, 1'b0}});
		script.push_back('{REQ_FEED, 8'hff, 1, '{8'hff, 1'b1, 1'b1, lzd_pkg::ST_OK, 1'b0}});
		script.push_back('{REQ_PULL, 8'h00, 1,
			'{8'h00, 1'b0, 1'b1, lzd_pkg::ST_MISORDER, 1'b0}});
		// Short match, length two at offset one: forwarded bytes.
		script.push_back('{REQ_FEED, 8'h20, 0, '0});
		script.push_back('{REQ_FEED, 8'h00, 0, '0});
		script.push_back('{REQ_FEED, 8'h55, 1,
			'{8'h00, 1'b0, 1'b0, lzd_pkg::ST_MISORDER, 1'b0}});
		script.push_back('{REQ_PULL, 8'h00, 0, '0});
		script.push_back('{REQ_PULL, 8'h00, 0, '0});
		// Length code 15 with a chained extension; the copy drains below.
		script.push_back('{REQ_FEED, 8'hf0, 0, '0});
		script.push_back('{REQ_FEED, 8'h02, 0, '0});
		script.push_back('{REQ_FEED, 8'hff, 0, '0});
		script.push_back('{REQ_FEED, 8'h01, 0, '0});
		for (i = 0; i < script.size(); i++)
			send_word(script[i].rt, script[i].b, script[i].typed, script[i].want);

		hold_req = 1;
		random_words(650, 1 << 30);
		write_reg(lzd_pkg::REG_LEN_EXT_OFF, 32'd1);
		random_words(650, 450);

		// Clean end of source: further feeds and pulls are misordered.
		write_reg(lzd_pkg::REG_SOURCE_LENGTH, src_cnt);
		send_word(REQ_FEED, 8'h00);
		send_word(REQ_PULL, 8'h00);

		// Finish on one sticky error, then show it holds.
		pick = $urandom_range(0, 4);
		case (pick)
			0: begin
				write_reg(lzd_pkg::REG_SOURCE_LENGTH, 32'hffffffff);
				write_reg(lzd_pkg::REG_OUTPUT_LENGTH, out_cnt);
				send_word(REQ_FEED, 8'h00);
			end
			1: begin
				write_reg(lzd_pkg::REG_SOURCE_LENGTH, 32'hffffffff);
				send_word(REQ_FEED, 8'h13);
				send_word(REQ_FEED, 8'hff);
				send_word(REQ_FEED, 8'hff);
			end
			2: begin
				write_reg(lzd_pkg::REG_SOURCE_LENGTH, src_cnt + 32'd1);
				send_word(REQ_FEED, 8'h20);
			end
			3: begin
				write_reg(lzd_pkg::REG_SOURCE_LENGTH, src_cnt + 32'd3);
				send_word(REQ_FEED, 8'h0f);
			end
			default: begin
				write_reg(lzd_pkg::REG_SOURCE_LENGTH, src_cnt + 32'd3);
				write_reg(lzd_pkg::REG_OUTPUT_LENGTH, out_cnt);
				send_word(REQ_FEED, 8'h0f);
			end
		endcase
		send_word(REQ_FEED, 8'h00);
		send_word(REQ_PULL, 8'h00);
		send_word(REQ_FEED, 8'hff);

		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
